FILE: rtl/elrp_pkg.sv
// Shared types, constants and helpers for the event loop recorder and player.
// Used by elrp_window and event_loop_recorder_player; depends on nothing else.
package elrp_pkg;

	localparam int MAX_EVENTS = 64;
	localparam int TIME_BITS  = 16;

	// Index into the event store, and a count that can hold MAX_EVENTS itself.
	localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);

	// Width of the shared window compare; covers double target plus margin.
	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS + 2 : 18;

	localparam int MSG_W   = 24;
	localparam int CFG_W   = 15;
	localparam int LEN_W   = 16;
	localparam int ENTRY_W = TIME_BITS + MSG_W;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [15:0] TARGET_RESET = 16'd2000;
	localparam logic [15:0] MARGIN_RESET = 16'd300;

	localparam logic REG_TARGET = 1'b0;
	localparam logic REG_MARGIN = 1'b1;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_ACK   = 1'b1;

	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_START   = 3'd1,
		CMD_RECORD  = 3'd2,
		CMD_FINAL   = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SNAP,
		S_ACK,
		S_SCAN_RD,
		S_SCAN,
		S_FLUSH
	} state_t;

	// Loop length as reported on the result words, saturated to 16 bits.
	function automatic logic [LEN_W-1:0] len_report(input logic [TIME_BITS-1:0] len);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(len);
		return (ext > CMP_W'(17'h0FFFF)) ? 16'hFFFF : ext[LEN_W-1:0];
	endfunction

endpackage

FILE: rtl/elrp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
module elrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/elrp_window.sv
// Shared half-open window compare: hit when lo <= x < hi.
// Serves both the snap search and the replay scan; uses elrp_pkg.
module elrp_window (
	input  logic [elrp_pkg::CMP_W-1:0] x,
	input  logic [elrp_pkg::CMP_W-1:0] lo,
	input  logic [elrp_pkg::CMP_W-1:0] hi,
	output logic                       hit
);

	assign hit = (x >= lo) && (x < hi);

endmodule

FILE: rtl/event_loop_recorder_player.sv
// Event loop recorder and player: records timestamped event words, snaps the loop
// length on finalize and replays stored events; uses elrp_pkg, elrp_window, elrp_ram.
// An acknowledge word is valid the cycle after its command is taken; finalize
// first runs the snap search in S_SNAP and then loads its acknowledge in S_ACK. A playing
// tick with stored events is busy in S_SCAN_RD, S_SCAN for each event, S_FLUSH and stalls.
// One command at a time; in_stall stays high meanwhile. Reset clears control state only.
module event_loop_recorder_player (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    cmd,
	input  logic [elrp_pkg::MSG_W-1:0]    event_message,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [elrp_pkg::MSG_W-1:0]    message_out,
	output logic [1:0]                    status,
	output logic [elrp_pkg::LEN_W-1:0]    loop_length_out,
	output logic                          last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [elrp_pkg::ADDR_W-1:0]   paddr,
	input  logic [elrp_pkg::DATA_W-1:0]   pwdata,
	output logic [elrp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int TB = elrp_pkg::TIME_BITS;
	localparam int CW = elrp_pkg::CMP_W;

	elrp_pkg::state_t state_q, state_d;
	elrp_pkg::mode_t  mode_q;

	logic [elrp_pkg::CFG_W-1:0] target_q, margin_q;
	logic [elrp_pkg::CNT_W-1:0] count_q;
	logic [TB-1:0]              elapsed_q, ppos_q, prev_q, len_q, lo_q, hi_q;
	logic [elrp_pkg::IDX_W-1:0] rd_idx_q;
	logic                       pend_q;
	logic [elrp_pkg::MSG_W-1:0] pend_msg_q;
	logic [1:0]                 snap_step_q;

	logic                       out_valid_q, kind_q, last_q;
	logic [elrp_pkg::MSG_W-1:0] msg_q;
	logic [1:0]                 status_q;
	logic [elrp_pkg::LEN_W-1:0] len_out_q;

	logic out_free, in_acc, cfg_wr;
	elrp_pkg::cmd_t cmd_c;

	// Decoded command actions and sequencer controls.
	logic acc_tick_rec, acc_tick_play, acc_start, acc_record, acc_restart;
	logic go_snap, snap_done, scan_adv, pend_take;
	logic out_load, o_kind, o_last;
	logic [elrp_pkg::MSG_W-1:0] o_msg;
	elrp_pkg::status_t          o_status;

	logic                       ram_re;
	logic [elrp_pkg::IDX_W-1:0] ram_raddr;
	logic [elrp_pkg::ENTRY_W-1:0] ram_rdata;
	logic [TB-1:0]              rd_time;
	logic [elrp_pkg::MSG_W-1:0] rd_msg;

	logic [TB:0]   pos_inc;
	logic          wrapped;
	logic [TB-1:0] pos_new;

	logic [CW-1:0] centre, margin_ext, snap_lo, snap_hi;
	logic [CW-1:0] unit_x, unit_lo, unit_hi;
	logic          unit_hit;
	logic          last_entry, table_full;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != elrp_pkg::S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign cmd_c    = elrp_pkg::cmd_t'(cmd);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == elrp_pkg::REG_MARGIN) ? elrp_pkg::DATA_W'(margin_q)
	                                                   : elrp_pkg::DATA_W'(target_q);

	assign {rd_time, rd_msg} = ram_rdata;

	assign pos_inc = {1'b0, ppos_q} + (TB+1)'(1);
	assign wrapped = pos_inc >= {1'b0, len_q};
	assign pos_new = wrapped ? '0 : pos_inc[TB-1:0];

	assign table_full = count_q == elrp_pkg::CNT_W'(elrp_pkg::MAX_EVENTS);
	assign last_entry = (elrp_pkg::CNT_W'(rd_idx_q) + elrp_pkg::CNT_W'(1)) == count_q;

	// Snap centres: target, half target, double target.
	always_comb begin
		case (snap_step_q)
			2'd0:    centre = CW'(target_q);
			2'd1:    centre = CW'(target_q >> 1);
			default: centre = CW'({target_q, 1'b0});
		endcase
	end

	assign margin_ext = CW'(margin_q);
	assign snap_lo    = (centre > margin_ext) ? centre - margin_ext : '0;
	assign snap_hi    = centre + margin_ext + CW'(1);

	assign unit_x  = (state_q == elrp_pkg::S_SNAP) ? CW'(elapsed_q) : CW'(rd_time);
	assign unit_lo = (state_q == elrp_pkg::S_SNAP) ? snap_lo : CW'(lo_q);
	assign unit_hi = (state_q == elrp_pkg::S_SNAP) ? snap_hi : CW'(hi_q);

	elrp_window u_window (
		.x   (unit_x),
		.lo  (unit_lo),
		.hi  (unit_hi),
		.hit (unit_hit)
	);

	elrp_ram #(
		.WIDTH (elrp_pkg::ENTRY_W),
		.DEPTH (elrp_pkg::MAX_EVENTS)
	) u_store (
		.clk   (clk),
		.we    (acc_record),
		.waddr (count_q[elrp_pkg::IDX_W-1:0]),
		.wdata ({elapsed_q, event_message}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d       = state_q;
		acc_tick_rec  = 1'b0;
		acc_tick_play = 1'b0;
		acc_start     = 1'b0;
		acc_record    = 1'b0;
		acc_restart   = 1'b0;
		go_snap       = 1'b0;
		snap_done     = 1'b0;
		scan_adv      = 1'b0;
		pend_take     = 1'b0;
		out_load      = 1'b0;
		o_kind        = elrp_pkg::KIND_ACK;
		o_msg         = '0;
		o_status      = elrp_pkg::ST_OK;
		o_last        = 1'b1;
		ram_re        = 1'b0;
		ram_raddr     = '0;
		case (state_q)
			elrp_pkg::S_IDLE: begin
				if (in_acc) begin
					case (cmd_c)
						elrp_pkg::CMD_TICK: begin
							out_load = 1'b0;
							if (mode_q == elrp_pkg::MODE_REC) begin
								acc_tick_rec = 1'b1;
							end else if (mode_q == elrp_pkg::MODE_PLAY && len_q != '0) begin
								acc_tick_play = 1'b1;
								if (count_q != '0) begin
									state_d = elrp_pkg::S_SCAN_RD;
								end
							end
						end
						elrp_pkg::CMD_START: begin
							acc_start = 1'b1;
							out_load  = 1'b1;
						end
						elrp_pkg::CMD_RECORD: begin
							out_load = 1'b1;
							if (mode_q != elrp_pkg::MODE_REC) begin
								o_status = elrp_pkg::ST_IGNORED;
							end else if (table_full) begin
								o_status = elrp_pkg::ST_DROPPED;
							end else begin
								acc_record = 1'b1;
							end
						end
						elrp_pkg::CMD_FINAL: begin
							if (mode_q != elrp_pkg::MODE_REC) begin
								out_load = 1'b1;
								o_status = elrp_pkg::ST_IGNORED;
							end else begin
								go_snap = 1'b1;
								state_d = elrp_pkg::S_SNAP;
							end
						end
						elrp_pkg::CMD_RESTART: begin
							out_load = 1'b1;
							if (mode_q != elrp_pkg::MODE_PLAY) begin
								o_status = elrp_pkg::ST_IGNORED;
							end else begin
								acc_restart = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
							o_status = elrp_pkg::ST_IGNORED;
						end
					endcase
				end
			end
			elrp_pkg::S_SNAP: begin
				if (unit_hit || snap_step_q == 2'd2) begin
					snap_done = 1'b1;
					state_d   = elrp_pkg::S_ACK;
				end
			end
			elrp_pkg::S_ACK: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = elrp_pkg::S_IDLE;
				end
			end
			elrp_pkg::S_SCAN_RD: begin
				ram_re  = 1'b1;
				state_d = elrp_pkg::S_SCAN;
			end
			elrp_pkg::S_SCAN: begin
				// A hit pushes the held hit out first, so it waits for a free output.
				if (!(unit_hit && pend_q && !out_free)) begin
					scan_adv  = 1'b1;
					pend_take = unit_hit;
					if (unit_hit && pend_q) begin
						out_load = 1'b1;
						o_kind   = elrp_pkg::KIND_EVENT;
						o_msg    = pend_msg_q;
						o_last   = 1'b0;
					end
					if (last_entry) begin
						state_d = elrp_pkg::S_FLUSH;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = rd_idx_q + elrp_pkg::IDX_W'(1);
					end
				end
			end
			elrp_pkg::S_FLUSH: begin
				if (!pend_q) begin
					state_d = elrp_pkg::S_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					o_kind   = elrp_pkg::KIND_EVENT;
					o_msg    = pend_msg_q;
					state_d  = elrp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = elrp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= elrp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= elrp_pkg::CFG_W'(elrp_pkg::TARGET_RESET);
			margin_q    <= elrp_pkg::CFG_W'(elrp_pkg::MARGIN_RESET);
			mode_q      <= elrp_pkg::MODE_IDLE;
			count_q     <= '0;
			elapsed_q   <= '0;
			ppos_q      <= '0;
			prev_q      <= '0;
			len_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			snap_step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == elrp_pkg::REG_MARGIN) begin
					margin_q <= pwdata[elrp_pkg::CFG_W-1:0];
				end else begin
					target_q <= pwdata[elrp_pkg::CFG_W-1:0];
				end
			end
			if (acc_tick_rec && elapsed_q != {TB{1'b1}}) begin
				elapsed_q <= elapsed_q + TB'(1);
			end
			if (acc_tick_play) begin
				// The scan uses the old position as its lower bound.
				lo_q     <= prev_q;
				hi_q     <= wrapped ? len_q : pos_new;
				ppos_q   <= pos_new;
				prev_q   <= pos_new;
				rd_idx_q <= '0;
				pend_q   <= 1'b0;
			end
			if (acc_start) begin
				count_q   <= '0;
				elapsed_q <= '0;
				mode_q    <= elrp_pkg::MODE_REC;
			end
			if (acc_record) begin
				count_q <= count_q + elrp_pkg::CNT_W'(1);
			end
			if (acc_restart) begin
				ppos_q <= '0;
				prev_q <= '0;
			end
			if (go_snap) begin
				snap_step_q <= '0;
			end
			if (state_q == elrp_pkg::S_SNAP && !snap_done) begin
				snap_step_q <= snap_step_q + 2'd1;
			end
			if (snap_done) begin
				len_q  <= unit_hit ? centre[TB-1:0] : elapsed_q;
				ppos_q <= '0;
				prev_q <= '0;
				mode_q <= elrp_pkg::MODE_PLAY;
			end
			if (scan_adv && !last_entry) begin
				rd_idx_q <= rd_idx_q + elrp_pkg::IDX_W'(1);
			end
			if (pend_take) begin
				pend_q <= 1'b1;
			end else if (state_q == elrp_pkg::S_FLUSH && out_load) begin
				pend_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take) begin
			pend_msg_q <= rd_msg;
		end
		if (out_load) begin
			kind_q    <= o_kind;
			msg_q     <= o_msg;
			status_q  <= o_status;
			last_q    <= o_last;
			len_out_q <= elrp_pkg::len_report(len_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign message_out     = msg_q;
	assign status          = status_q;
	assign loop_length_out = len_out_q;
	assign last            = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= elrp_pkg::CNT_W'(elrp_pkg::MAX_EVENTS))
		else $error("event count exceeds store depth");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == elrp_pkg::S_SCAN |-> elrp_pkg::CNT_W'(rd_idx_q) < count_q)
		else $error("scan reads beyond recorded events");

	a_pos_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == elrp_pkg::MODE_PLAY && len_q != '0) |-> ppos_q < len_q)
		else $error("play position outside loop length");

	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == elrp_pkg::S_SCAN || state_q == elrp_pkg::S_FLUSH))
		else $error("held replay word outside a scan");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("output word overwritten while stalled");
`endif

endmodule

FILE: dv/tb_event_loop_recorder_player.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_loop_recorder_player: drives commands and APB
// register writes, and predicts every output word with a behavioral copy of the looper.
// Depends on rtl/elrp_pkg.sv and rtl/event_loop_recorder_player.sv.
module tb_event_loop_recorder_player;

	localparam logic [elrp_pkg::ADDR_W-1:0] ADDR_TARGET = {elrp_pkg::REG_TARGET, 2'b00};
	localparam logic [elrp_pkg::ADDR_W-1:0] ADDR_MARGIN = {elrp_pkg::REG_MARGIN, 2'b00};
	localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
	localparam logic [elrp_pkg::CFG_W-1:0] CFG_MAX = '1;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 60;
	localparam int TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic                       kind;
		logic [elrp_pkg::MSG_W-1:0] msg;
		logic [1:0]                 status;
		logic [elrp_pkg::LEN_W-1:0] len;
		logic                       last;
	} word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [2:0]                    cmd = elrp_pkg::CMD_TICK;
	logic [elrp_pkg::MSG_W-1:0]    event_message = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          kind;
	logic [elrp_pkg::MSG_W-1:0]    message_out;
	logic [1:0]                    status;
	logic [elrp_pkg::LEN_W-1:0]    loop_length_out;
	logic                          last;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [elrp_pkg::ADDR_W-1:0]   paddr = '0;
	logic [elrp_pkg::DATA_W-1:0]   pwdata = '0;
	logic [elrp_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// Behavioral copy of the looper state and its registers.
	logic [elrp_pkg::TIME_BITS-1:0] rec_times [elrp_pkg::MAX_EVENTS];
	logic [elrp_pkg::MSG_W-1:0]     rec_msgs [elrp_pkg::MAX_EVENTS];
	int unsigned                    rec_count = 0;
	logic [elrp_pkg::TIME_BITS-1:0] rec_clock = '0;
	logic [elrp_pkg::TIME_BITS-1:0] play_pos = '0;
	logic [elrp_pkg::TIME_BITS-1:0] play_prev = '0;
	logic [elrp_pkg::TIME_BITS-1:0] loop_len = '0;
	elrp_pkg::mode_t                looper_mode = elrp_pkg::MODE_IDLE;
	logic [elrp_pkg::CFG_W-1:0]     cfg_target = elrp_pkg::CFG_W'(elrp_pkg::TARGET_RESET);
	logic [elrp_pkg::CFG_W-1:0]     cfg_margin = elrp_pkg::CFG_W'(elrp_pkg::MARGIN_RESET);

	word_t due_words [$];
	int    errors = 0;
	int    words_sent = 0;
	bit    tx_idle = 1'b1;
	bit    rx_idle = 1'b1;
	int    hold_cycles = 0;
	int    hold_serial = 0;
	int    hold_seen = 0;
	int    stall_left = 0;

	event_loop_recorder_player uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.event_message   (event_message),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.message_out     (message_out),
		.status          (status),
		.loop_length_out (loop_length_out),
		.last            (last),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic logic [elrp_pkg::MSG_W-1:0] rand_msg();
		return elrp_pkg::MSG_W'($urandom());
	endfunction

	// The receiver holds off, starting at the next clock edge; n sets how long.
	task automatic hold_output(input int n);
		hold_cycles = n;
		hold_serial++;
	endtask

	function automatic void push_word(input logic k, input logic [elrp_pkg::MSG_W-1:0] m,
			input logic [1:0] st, input logic lst);
		word_t w;
		w.kind = k;
		w.msg = m;
		w.status = st;
		w.len = elrp_pkg::LEN_W'(loop_len);
		w.last = lst;
		due_words.push_back(w);
	endfunction

	function automatic bit in_window(input int unsigned len, input int unsigned centre);
		int unsigned lo;
		int unsigned m;
		m = 32'(cfg_margin);
		lo = (centre > m) ? centre - m : 0;
		return len >= lo && len <= centre + m;
	endfunction

	// Target first, then half target, then double target.
	function automatic int unsigned snapped_length(input int unsigned len);
		int unsigned t;
		t = 32'(cfg_target);
		if (in_window(len, t))
			return t;
		if (in_window(len, t / 2))
			return t / 2;
		if (in_window(len, t * 2))
			return t * 2;
		return len;
	endfunction

	task automatic looper_step(input logic [2:0] c, input logic [elrp_pkg::MSG_W-1:0] m);
		logic [1:0] st;
		int unsigned p;
		int unsigned t;
		int i;
		bit wrapped;
		bit fire;
		logic [elrp_pkg::MSG_W-1:0] hits [$];
		st = elrp_pkg::ST_OK;
		if (c == elrp_pkg::CMD_TICK) begin
			if (looper_mode == elrp_pkg::MODE_REC) begin
				if (rec_clock != '1)
					rec_clock++;
			end else if (looper_mode == elrp_pkg::MODE_PLAY && loop_len != 0) begin
				p = 32'(play_pos) + 1;
				wrapped = p >= 32'(loop_len);
				if (wrapped)
					p = 0;
				play_pos = elrp_pkg::TIME_BITS'(p);
				for (i = 0; i < int'(rec_count); i++) begin
					t = 32'(rec_times[i]);
					// A wrap replays the tail of the loop and any event before the new position.
					if (wrapped)
						fire = (t >= 32'(play_prev) && t < 32'(loop_len)) || t < p;
					else
						fire = t >= 32'(play_prev) && t < p;
					if (fire)
						hits.push_back(rec_msgs[i]);
				end
				play_prev = elrp_pkg::TIME_BITS'(p);
				foreach (hits[k])
					push_word(elrp_pkg::KIND_EVENT, hits[k], elrp_pkg::ST_OK,
						k == hits.size() - 1);
			end
		end else begin
			case (c)
				elrp_pkg::CMD_START: begin
					rec_count = 0;
					rec_clock = '0;
					looper_mode = elrp_pkg::MODE_REC;
				end
				elrp_pkg::CMD_RECORD: begin
					if (looper_mode != elrp_pkg::MODE_REC) begin
						st = elrp_pkg::ST_IGNORED;
					end else if (rec_count >= elrp_pkg::MAX_EVENTS) begin
						st = elrp_pkg::ST_DROPPED;
					end else begin
						rec_times[rec_count] = rec_clock;
						rec_msgs[rec_count] = m;
						rec_count++;
					end
				end
				elrp_pkg::CMD_FINAL: begin
					if (looper_mode != elrp_pkg::MODE_REC) begin
						st = elrp_pkg::ST_IGNORED;
					end else begin
						loop_len = elrp_pkg::TIME_BITS'(snapped_length(32'(rec_clock)));
						play_pos = '0;
						play_prev = '0;
						looper_mode = elrp_pkg::MODE_PLAY;
					end
				end
				elrp_pkg::CMD_RESTART: begin
					if (looper_mode != elrp_pkg::MODE_PLAY) begin
						st = elrp_pkg::ST_IGNORED;
					end else begin
						play_pos = '0;
						play_prev = '0;
					end
				end
				default: st = elrp_pkg::ST_IGNORED;
			endcase
			push_word(elrp_pkg::KIND_ACK, '0, st, 1'b1);
		end
	endtask

	// Valid stays high across back-to-back words, so it is only lowered for a gap.
	task automatic send_word(input logic [2:0] c, input logic [elrp_pkg::MSG_W-1:0] m);
		int gap;
		in_valid <= 1'b1;
		cmd <= c;
		event_message <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		looper_step(c, m);
		words_sent++;
		gap = tx_idle ? int'($urandom_range(0, 3)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(elrp_pkg::CMD_TICK, rand_msg());
	endtask

	// Waits for every due word, then for a tick that is still scanning the store.
	task automatic settle();
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes a register with junk in the unused upper bits, then reads it back.
	task automatic set_register(input logic [elrp_pkg::ADDR_W-1:0] a,
			input logic [elrp_pkg::CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= {17'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (a == ADDR_TARGET)
			cfg_target = v;
		else
			cfg_margin = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== elrp_pkg::DATA_W'(v))
			flag_mismatch("register read back", prdata, 32'(v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [elrp_pkg::CFG_W-1:0] target,
			input logic [elrp_pkg::CFG_W-1:0] margin);
		settle();
		set_register(ADDR_TARGET, target);
		set_register(ADDR_MARGIN, margin);
	endtask

	task automatic record_for(input int n_ticks);
		send_word(elrp_pkg::CMD_START, rand_msg());
		send_word(elrp_pkg::CMD_RECORD, rand_msg());
		send_ticks(n_ticks);
		send_word(elrp_pkg::CMD_FINAL, rand_msg());
		send_ticks(3);
	endtask

	task automatic test_commands();
		int c;
		// Out of reset the looper is idle: ticks do nothing, the rest is ignored.
		send_word(elrp_pkg::CMD_TICK, '0);
		send_word(elrp_pkg::CMD_RECORD, '1);
		send_word(elrp_pkg::CMD_FINAL, '0);
		send_word(elrp_pkg::CMD_RESTART, '0);
		for (c = int'(CMD_UNDEF_LO); c <= int'(CMD_UNDEF_HI); c++)
			send_word(3'(c), rand_msg());
		// An empty recording gives a zero length loop whose ticks do nothing.
		send_word(elrp_pkg::CMD_START, '0);
		send_word(elrp_pkg::CMD_FINAL, '0);
		send_word(elrp_pkg::CMD_TICK, '0);
		send_word(elrp_pkg::CMD_RESTART, '0);
		send_word(elrp_pkg::CMD_RECORD, 24'h123456);
		send_word(elrp_pkg::CMD_FINAL, '0);
		configure(15'd4, 15'd0);
		send_word(elrp_pkg::CMD_START, '0);
		send_word(elrp_pkg::CMD_RECORD, '0);
		send_word(elrp_pkg::CMD_TICK, '0);
		send_word(elrp_pkg::CMD_RECORD, '1);
		send_ticks(2);
		send_word(elrp_pkg::CMD_RECORD, 24'hA5A5A5);
		send_word(elrp_pkg::CMD_TICK, '0);
		send_word(elrp_pkg::CMD_FINAL, '0);
		send_ticks(6);
		send_word(elrp_pkg::CMD_RESTART, '0);
		send_ticks(2);
		send_word(elrp_pkg::CMD_START, '0);
	endtask

	task automatic test_snap_windows();
		configure(15'd6, 15'd1);
		record_for(6);
		record_for(3);
		record_for(12);
		record_for(9);
		record_for(14);
		// The margin exceeds the target, so the window starts at zero.
		configure(15'd2, 15'd3);
		record_for(0);
		record_for(8);
		configure(15'd1, 15'd0);
		record_for(0);
		record_for(1);
		record_for(2);
		record_for(3);
	endtask

	task automatic test_table_full();
		int i;
		configure(15'd3, 15'd0);
		send_word(elrp_pkg::CMD_START, '0);
		for (i = 0; i < elrp_pkg::MAX_EVENTS + 2; i++)
			send_word(elrp_pkg::CMD_RECORD, rand_msg());
		send_ticks(3);
		send_word(elrp_pkg::CMD_RECORD, rand_msg());
		send_word(elrp_pkg::CMD_FINAL, '0);
		// Every stored event sits at time zero, so one tick replays the full table
		// while the receiver holds off and the block backs up.
		hold_output(600);
		send_ticks(8);
		settle();
		send_ticks(4);
	endtask

	function automatic logic [elrp_pkg::CFG_W-1:0] pick_setting(input int small_hi);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CFG_MAX;
			2: return elrp_pkg::CFG_W'($urandom());
			default: return elrp_pkg::CFG_W'($urandom_range(0, small_hi));
		endcase
	endfunction

	function automatic logic [2:0] noise_cmd();
		return 3'($urandom_range(0, 7));
	endfunction

	task automatic test_random_sessions();
		int first;
		int session;
		int tk_left;
		int ev_left;
		int steps;
		int r;
		first = words_sent;
		session = 0;
		while (words_sent - first < RANDOM_ITEMS) begin
			if (session % 3 == 0) begin
				configure(pick_setting(30) | 15'd1, pick_setting(4));
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end else if (session % 4 == 1) begin
				settle();
			end
			send_word(elrp_pkg::CMD_START, rand_msg());
			tk_left = int'($urandom_range(1, 24));
			ev_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 68)) :
				int'($urandom_range(0, 10));
			while (tk_left > 0 || ev_left > 0) begin
				if ($urandom_range(0, 11) == 0)
					send_word(noise_cmd(), rand_msg());
				else if (ev_left > 0 && (tk_left == 0 || $urandom_range(0, 1) == 1)) begin
					send_word(elrp_pkg::CMD_RECORD, rand_msg());
					ev_left--;
				end else begin
					send_word(elrp_pkg::CMD_TICK, rand_msg());
					tk_left--;
				end
			end
			// Now and then the recording is left unfinished.
			if ($urandom_range(0, 9) != 0)
				send_word(elrp_pkg::CMD_FINAL, rand_msg());
			if (session == 1)
				hold_output(300);
			steps = int'($urandom_range(4, 40));
			repeat (steps) begin
				r = int'($urandom_range(0, 19));
				if (r == 0)
					send_word(elrp_pkg::CMD_RESTART, rand_msg());
				else if (r == 1)
					send_word(noise_cmd(), rand_msg());
				else
					send_word(elrp_pkg::CMD_TICK, rand_msg());
			end
			session++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen = hold_serial;
			stall_left = hold_cycles;
		end else if (out_valid && !out_stall) begin
			stall_left = rx_idle ? int'($urandom_range(0, 3)) : 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : check_words
		word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_words.size() == 0) begin
				flag_mismatch("word with none due", 32'(message_out), 32'd0);
			end else begin
				want = due_words.pop_front();
				if (kind !== want.kind)
					flag_mismatch("kind", 32'(kind), 32'(want.kind));
				if (message_out !== want.msg)
					flag_mismatch("message_out", 32'(message_out), 32'(want.msg));
				if (status !== want.status)
					flag_mismatch("status", 32'(status), 32'(want.status));
				if (loop_length_out !== want.len)
					flag_mismatch("loop_length_out", 32'(loop_length_out), 32'(want.len));
				if (last !== want.last)
					flag_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_event_loop_recorder_player failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_snap_windows();
		test_table_full();
		test_random_sessions();
		settle();
		if (errors == 0)
			$display("tb_event_loop_recorder_player passed");
		else
			$display("tb_event_loop_recorder_player failed");
		$finish;
	end

endmodule
